// ===== sv/sha_pkg.sv =====
// shared types, constants and helper functions of the sha-1 hash engine
package sha_pkg;

   // sizes of the message block and digest
   localparam int WordCount  = 5;
   localparam int BlockBytes = 64;
   localparam int SchedWords = 16;
   localparam int LenPos     = 56;
   localparam int LenBytes   = 8;
   localparam int Rounds     = 80;
   localparam int StageLen   = 20;
   localparam int RoundW     = $clog2(Rounds);
   localparam int FillW      = $clog2(BlockBytes);
   localparam int LenIdxW    = $clog2(LenBytes);
   localparam int WordIdxW   = $clog2(WordCount);

   // queue between front and back
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // padding marker byte
   localparam logic [7:0] PadMark = 8'h80;

   // round constants
   localparam logic [31:0] RoundK0 = 32'h5A827999;
   localparam logic [31:0] RoundK1 = 32'h6ED9EBA1;
   localparam logic [31:0] RoundK2 = 32'h8F1BBCDC;
   localparam logic [31:0] RoundK3 = 32'hCA62C1D6;

   // request and response payloads
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } req_payload_type;

   typedef struct packed {
      logic [31:0]         digest_word;
      logic [WordIdxW-1:0] word_index;
      logic                last_word;
   } rsp_payload_type;

   // back end states
   typedef enum logic [2:0] {
      ST_ABSORB,
      ST_PAD,
      ST_ROUND,
      ST_ADD,
      ST_DIGEST
   } core_state_type;

   // padding phases
   typedef enum logic [1:0] {
      PH_MARK,
      PH_ZERO,
      PH_LEN,
      PH_DONE
   } pad_phase_type;

   // initial chaining value of one word
   function automatic logic [31:0] init_value(input logic [WordIdxW-1:0] idx);
      logic [31:0] v;
      case (idx)
         3'd0:    v = 32'h67452301;
         3'd1:    v = 32'hEFCDAB89;
         3'd2:    v = 32'h98BADCFE;
         3'd3:    v = 32'h10325476;
         default: v = 32'hC3D2E1F0;
      endcase
      return v;
   endfunction

   // rotate left by a constant amount
   function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned amt);
      return (v << amt) | (v >> (32 - amt));
   endfunction

endpackage

// ===== sv/sha_front.sv =====
// front end: accepts request transfers, drops empty items and queues the rest
module sha_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  sha_pkg::req_payload_type req_payload,
   output logic                     q_valid,
   input  logic                     q_ready,
   output sha_pkg::req_payload_type q_item
);
   import sha_pkg::*;

   req_payload_type         entry_ff [QueueDepth];
   req_payload_type         entry_in [QueueDepth];
   logic [QueuePtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]    count_ff, count_in;
   logic                    push;
   logic                    pop;

   // handshake on both sides of the queue
   assign req_ready = (count_ff != QueueCntW'(QueueDepth));
   assign q_valid   = (count_ff != '0);
   assign q_item    = entry_ff[rd_ptr_ff];

   // items with neither a byte nor an end mark carry nothing
   assign push = req_valid && req_ready
                 && (req_payload.has_byte || req_payload.end_of_message);
   assign pop  = q_valid && q_ready;

   // entry write, pointer and count update
   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = req_payload;
         wr_ptr_in           = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   // queue storage, no reset needed
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/sha_core.sv =====
// back end: byte packing, padding, 80-round compression and digest output
module sha_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   output logic                     q_ready,
   input  sha_pkg::req_payload_type q_item,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output sha_pkg::rsp_payload_type rsp_payload
);
   import sha_pkg::*;

   core_state_type       state_ff, state_in;
   pad_phase_type        phase_ff, phase_in;
   logic                 pad_active_ff, pad_active_in;
   logic [FillW-1:0]     fill_ff, fill_in;
   logic [63:0]          bit_length_ff, bit_length_in;
   logic [LenIdxW-1:0]   len_idx_ff, len_idx_in;
   logic [RoundW-1:0]    round_ff, round_in;
   logic [WordIdxW-1:0]  word_idx_ff, word_idx_in;
   logic [31:0]          chain_ff [WordCount];
   logic [31:0]          chain_in [WordCount];
   logic [31:0]          sched_ff [SchedWords];
   logic [31:0]          sched_in [SchedWords];
   logic [31:0]          a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]          a_in, b_in, c_in, d_in, e_in;
   logic                 out_valid_ff, out_valid_in;
   rsp_payload_type      out_ff, out_in;

   logic                 push_en;
   logic [7:0]           push_val;
   logic                 block_full;
   logic                 out_free;
   logic [31:0]          f_val;
   logic [31:0]          k_val;
   logic [31:0]          t_val;
   logic [31:0]          w_next;

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;
   assign out_free    = !out_valid_ff || rsp_ready;

   // round function and constant by stage
   always_comb begin
      if (round_ff < RoundW'(StageLen)) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = RoundK0;
      end else if (round_ff < RoundW'(2 * StageLen)) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = RoundK1;
      end else if (round_ff < RoundW'(3 * StageLen)) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = RoundK2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = RoundK3;
      end
   end

   assign t_val  = rotl32(a_ff, 5) + f_val + e_ff + k_val + sched_ff[0];
   assign w_next = rotl32(sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0], 1);

   // next state and datapath control
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      pad_active_in = pad_active_ff;
      fill_in       = fill_ff;
      bit_length_in = bit_length_ff;
      len_idx_in    = len_idx_ff;
      round_in      = round_ff;
      word_idx_in   = word_idx_ff;
      chain_in      = chain_ff;
      sched_in      = sched_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      c_in          = c_ff;
      d_in          = d_ff;
      e_in          = e_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      q_ready       = 1'b0;
      push_en       = 1'b0;
      push_val      = '0;

      // output register drains on a transfer
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_ABSORB: begin
            q_ready = 1'b1;
            if (q_valid) begin
               if (q_item.has_byte) begin
                  push_en       = 1'b1;
                  push_val      = q_item.data_byte;
                  bit_length_in = bit_length_ff + 64'd8;
               end
               if (q_item.end_of_message) begin
                  pad_active_in = 1'b1;
                  phase_in      = PH_MARK;
                  state_in      = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            case (phase_ff)
               PH_MARK: begin
                  push_en  = 1'b1;
                  push_val = PadMark;
                  phase_in = PH_ZERO;
               end
               PH_ZERO: begin
                  if (fill_ff == FillW'(LenPos)) begin
                     phase_in   = PH_LEN;
                     len_idx_in = '0;
                  end else begin
                     push_en  = 1'b1;
                     push_val = 8'h00;
                  end
               end
               PH_LEN: begin
                  push_en    = 1'b1;
                  push_val   = bit_length_ff[{~len_idx_ff, 3'b000} +: 8];
                  len_idx_in = len_idx_ff + 1'b1;
                  if (len_idx_ff == LenIdxW'(LenBytes - 1)) begin
                     phase_in = PH_DONE;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_ROUND: begin
            for (int i = 0; i < SchedWords - 1; i++) begin
               sched_in[i] = sched_ff[i + 1];
            end
            sched_in[SchedWords - 1] = w_next;
            e_in     = d_ff;
            d_in     = c_ff;
            c_in     = rotl32(b_ff, 30);
            b_in     = a_ff;
            a_in     = t_val;
            round_in = round_ff + 1'b1;
            if (round_ff == RoundW'(Rounds - 1)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            chain_in[4] = chain_ff[4] + e_ff;
            if (pad_active_ff && (phase_ff == PH_DONE)) begin
               word_idx_in = '0;
               state_in    = ST_DIGEST;
            end else if (pad_active_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_ABSORB;
            end
         end
         ST_DIGEST: begin
            if (out_free) begin
               out_valid_in       = 1'b1;
               out_in.digest_word = chain_ff[word_idx_ff];
               out_in.word_index  = word_idx_ff;
               out_in.last_word   = (word_idx_ff == WordIdxW'(WordCount - 1));
               word_idx_in        = word_idx_ff + 1'b1;
               if (word_idx_ff == WordIdxW'(WordCount - 1)) begin
                  for (int i = 0; i < WordCount; i++) begin
                     chain_in[i] = init_value(WordIdxW'(i));
                  end
                  fill_in       = '0;
                  bit_length_in = '0;
                  pad_active_in = 1'b0;
                  state_in      = ST_ABSORB;
               end
            end
         end
         default: begin
            state_in = ST_ABSORB;
         end
      endcase

      // byte shifts into the schedule line, a full block starts the rounds
      block_full = push_en && (fill_ff == FillW'(BlockBytes - 1));
      if (push_en) begin
         for (int i = 0; i < SchedWords - 1; i++) begin
            sched_in[i] = {sched_ff[i][23:0], sched_ff[i + 1][31:24]};
         end
         sched_in[SchedWords - 1] = {sched_ff[SchedWords - 1][23:0], push_val};
         fill_in = fill_ff + 1'b1;
      end
      if (block_full) begin
         a_in     = chain_ff[0];
         b_in     = chain_ff[1];
         c_in     = chain_ff[2];
         d_in     = chain_ff[3];
         e_in     = chain_ff[4];
         round_in = '0;
         state_in = ST_ROUND;
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ABSORB;
      end else begin
         state_ff <= state_in;
      end
   end

   // control and chaining registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_MARK;
         pad_active_ff <= 1'b0;
         fill_ff       <= '0;
         bit_length_ff <= '0;
         len_idx_ff    <= '0;
         round_ff      <= '0;
         word_idx_ff   <= '0;
         out_valid_ff  <= 1'b0;
         for (int i = 0; i < WordCount; i++) begin
            chain_ff[i] <= init_value(WordIdxW'(i));
         end
      end else begin
         phase_ff      <= phase_in;
         pad_active_ff <= pad_active_in;
         fill_ff       <= fill_in;
         bit_length_ff <= bit_length_in;
         len_idx_ff    <= len_idx_in;
         round_ff      <= round_in;
         word_idx_ff   <= word_idx_in;
         out_valid_ff  <= out_valid_in;
         chain_ff      <= chain_in;
      end
   end

   // schedule line, working variables and output payload
   always_ff @(posedge clock) begin
      sched_ff <= sched_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      e_ff     <= e_in;
      out_ff   <= out_in;
   end

endmodule

// ===== sv/sha1_hash_engine.sv =====
// sha-1 hash engine: byte stream in, five digest words out per message
//
// Request channel (req_valid / req_ready / req_payload) takes one message
// byte per transfer; has_byte marks a real byte and end_of_message closes
// the message. An item with neither flag is taken and ignored.
// A four-entry front queue takes requests while the back end compresses.
// The back end packs bytes big-endian into a 16-word schedule line, one byte
// a cycle while bytes are queued. A full 64-byte block runs the 80-round
// compression at one round a cycle, then folds the working variables into
// the chaining values; meanwhile the back end takes no bytes.
// At end of message the padding bytes are generated one per cycle outside
// compression (and a second block when the length field does not fit).
// The five digest words then leave on the response channel (rsp_valid /
// rsp_ready / rsp_payload), one per cycle while the receiver is ready,
// through an output register. When the receiver stalls the output register
// holds its word; the back end waits only while digest words are still to
// be loaded, and absorbs the next message meanwhile otherwise.
// Reset (synchronous, active high) empties the queue, drops any partial
// message and restores the initial chaining values.
module sha1_hash_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  sha_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output sha_pkg::rsp_payload_type rsp_payload
);
   import sha_pkg::*;

   logic            q_valid;
   logic            q_ready;
   req_payload_type q_item;

   // request queue
   sha_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_item      (q_item)
   );

   // hashing back end
   sha_core u_core (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_item      (q_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
